// ----- rtl/qsvn_pkg.sv -----
package qsvn_pkg;

  // Table geometry and field widths.
  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = 10;
  localparam int ADDR_W       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int POS_W        = 16;
  localparam int SUM_W        = 32;
  localparam int NRM_W        = 16;
  localparam int M_W          = 36;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [NRM_W-1:0]  nrm_t;
  typedef logic signed [M_W-1:0]    mcomp_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_STRIP = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CLEAR,
    OP_QUAD,
    OP_READ
  } op_kind_t;

  // One classified operation queued between the front and the back.
  typedef struct packed {
    op_kind_t kind;
    idx_t     idx_a;
    idx_t     idx_b;
    idx_t     idx_c;
    idx_t     idx_d;
    pos_t     pos_x;
    pos_t     pos_y;
    pos_t     pos_z;
  } op_t;

  typedef struct packed {
    logic   start;
    mcomp_t m_x;
    mcomp_t m_y;
    mcomp_t m_z;
  } norm_req_t;

  typedef struct packed {
    logic done;
    nrm_t n_x;
    nrm_t n_y;
    nrm_t n_z;
  } norm_res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_NEWELL,
    BK_NORM,
    BK_ACC_RD,
    BK_ACC_WR,
    BK_RD_WAIT
  } back_state_t;

  typedef enum logic [2:0] {
    NM_IDLE,
    NM_MAX,
    NM_SCALE,
    NM_SQUARE,
    NM_SQRT,
    NM_DIVLD,
    NM_DIV,
    NM_DONE
  } norm_state_t;

  function automatic logic in_table(idx_t idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

  function automatic addr_t to_addr(idx_t idx);
    return addr_t'(idx);
  endfunction

endpackage

// ----- rtl/qsvn_front.sv -----
module qsvn_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  qsvn_pkg::cmd_t   cmd,
  input  qsvn_pkg::idx_t   vertex_index,
  input  logic             strip_start,
  input  qsvn_pkg::pos_t   pos_x,
  input  qsvn_pkg::pos_t   pos_y,
  input  qsvn_pkg::pos_t   pos_z,
  output logic             op_push,
  output qsvn_pkg::op_t    op
);
  import qsvn_pkg::*;

  idx_t prior_first_r, prior_first_nxt;
  idx_t prior_second_r, prior_second_nxt;
  idx_t incoming_r, incoming_nxt;
  logic have_prior_r, have_prior_nxt;
  logic half_held_r, half_held_nxt;
  logic hp, hh;

  // Classify the beat and track the strip pairing.
  always_comb begin
    hp               = have_prior_r & ~strip_start;
    hh               = half_held_r & ~strip_start;
    prior_first_nxt  = prior_first_r;
    prior_second_nxt = prior_second_r;
    incoming_nxt     = incoming_r;
    have_prior_nxt   = have_prior_r;
    half_held_nxt    = half_held_r;
    op_push          = 1'b0;
    op.kind          = OP_LOAD;
    op.idx_a         = vertex_index;
    op.idx_b         = vertex_index;
    op.idx_c         = vertex_index;
    op.idx_d         = vertex_index;
    op.pos_x         = pos_x;
    op.pos_y         = pos_y;
    op.pos_z         = pos_z;
    case (cmd)
      CMD_LOAD: begin
        op_push = accept;
        op.kind = OP_LOAD;
      end
      CMD_CLEAR: begin
        op_push = accept;
        op.kind = OP_CLEAR;
      end
      CMD_READ: begin
        op_push = accept;
        op.kind = OP_READ;
      end
      CMD_STRIP: begin
        op.kind  = OP_QUAD;
        op.idx_a = prior_first_r;
        op.idx_b = prior_second_r;
        op.idx_c = incoming_r;
        op.idx_d = vertex_index;
        if (accept) begin
          if (!hh) begin
            incoming_nxt   = vertex_index;
            half_held_nxt  = 1'b1;
            have_prior_nxt = hp;
          end else begin
            op_push          = hp;
            prior_first_nxt  = incoming_r;
            prior_second_nxt = vertex_index;
            have_prior_nxt   = 1'b1;
            half_held_nxt    = 1'b0;
          end
        end
      end
      default: begin
        op_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_first_r  <= '0;
      prior_second_r <= '0;
      incoming_r     <= '0;
      have_prior_r   <= 1'b0;
      half_held_r    <= 1'b0;
    end else begin
      prior_first_r  <= prior_first_nxt;
      prior_second_r <= prior_second_nxt;
      incoming_r     <= incoming_nxt;
      have_prior_r   <= have_prior_nxt;
      half_held_r    <= half_held_nxt;
    end
  end

endmodule

// ----- rtl/qsvn_op_fifo.sv -----
module qsvn_op_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qsvn_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output qsvn_pkg::op_t  head,
  output logic           empty
);
  import qsvn_pkg::*;

  op_t                mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push, do_pop;

  assign full    = count_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

endmodule

// ----- rtl/qsvn_norm.sv -----
module qsvn_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qsvn_pkg::norm_req_t  req,
  output qsvn_pkg::norm_res_t  res
);
  import qsvn_pkg::*;

  norm_state_t state_r, state_nxt;
  logic [M_W-1:0] mag_r [3];
  logic           neg_r [3];
  logic [M_W-1:0] mx_r;
  logic [63:0]    ss_r, v_r, res_r, bit_r;
  logic [31:0]    len_r;
  logic [32:0]    rem_r;
  logic [15:0]    lo_r, q_r;
  logic [3:0]     step_r;
  logic [1:0]     comp_r;
  nrm_t           n_r [3];

  logic [61:0]    sq;
  logic [63:0]    ss_fin;
  logic [63:0]    rb;
  logic           sq_ge;
  logic [63:0]    res_n, v_n;
  logic [46:0]    num;
  logic [32:0]    t, dsub;
  logic           d_ge;
  logic [15:0]    q_n;
  nrm_t           n_fin;
  logic           too_big, too_small;

  // Shared arithmetic of each step.
  always_comb begin
    sq        = mag_r[comp_r][30:0] * mag_r[comp_r][30:0];
    ss_fin    = ss_r + 64'(sq);
    rb        = res_r + bit_r;
    sq_ge     = v_r >= rb;
    res_n     = sq_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    v_n       = sq_ge ? (v_r - rb) : v_r;
    num       = {mag_r[comp_r][30:0], 16'b0} >> 1;
    num       = num + 47'(len_r >> 1);
    t         = {rem_r[31:0], lo_r[15]};
    dsub      = t - {1'b0, len_r};
    d_ge      = t >= {1'b0, len_r};
    q_n       = {q_r[14:0], d_ge};
    if (neg_r[comp_r]) n_fin = nrm_t'(-$signed({1'b0, q_n}));
    else if (q_n[15]) n_fin = nrm_t'(16'h7fff);
    else n_fin = nrm_t'(q_n);
    too_big   = mx_r[M_W-1:31] != '0;
    too_small = !mx_r[30];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      NM_IDLE:   if (req.start) state_nxt = NM_MAX;
      NM_MAX:    state_nxt = NM_SCALE;
      NM_SCALE: begin
        if (mx_r == '0) state_nxt = NM_DONE;
        else if (!too_big && !too_small) state_nxt = NM_SQUARE;
      end
      NM_SQUARE: if (comp_r == 2'd2) state_nxt = NM_SQRT;
      NM_SQRT:   if (bit_r[0]) state_nxt = NM_DIVLD;
      NM_DIVLD:  state_nxt = NM_DIV;
      NM_DIV: begin
        if (step_r == 4'd15) state_nxt = (comp_r == 2'd2) ? NM_DONE : NM_DIVLD;
      end
      NM_DONE:   state_nxt = NM_IDLE;
      default:   state_nxt = NM_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    res.done = state_r == NM_DONE;
    res.n_x  = n_r[0];
    res.n_y  = n_r[1];
    res.n_z  = n_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= NM_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      NM_IDLE: begin
        mag_r[0] <= req.m_x[M_W-1] ? M_W'(-req.m_x) : M_W'(req.m_x);
        mag_r[1] <= req.m_y[M_W-1] ? M_W'(-req.m_y) : M_W'(req.m_y);
        mag_r[2] <= req.m_z[M_W-1] ? M_W'(-req.m_z) : M_W'(req.m_z);
        neg_r[0] <= req.m_x[M_W-1];
        neg_r[1] <= req.m_y[M_W-1];
        neg_r[2] <= req.m_z[M_W-1];
        n_r[0]   <= '0;
        n_r[1]   <= '0;
        n_r[2]   <= '0;
      end
      NM_MAX: begin
        if (mag_r[0] >= mag_r[1] && mag_r[0] >= mag_r[2]) mx_r <= mag_r[0];
        else if (mag_r[1] >= mag_r[2]) mx_r <= mag_r[1];
        else mx_r <= mag_r[2];
        comp_r <= 2'd0;
        ss_r   <= '0;
      end
      NM_SCALE: begin
        if (mx_r != '0 && too_big) begin
          mx_r     <= mx_r >> 1;
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else if (mx_r != '0 && too_small) begin
          mx_r     <= mx_r << 1;
          mag_r[0] <= mag_r[0] << 1;
          mag_r[1] <= mag_r[1] << 1;
          mag_r[2] <= mag_r[2] << 1;
        end
      end
      NM_SQUARE: begin
        ss_r   <= ss_fin;
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        v_r    <= ss_fin;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
      end
      NM_SQRT: begin
        v_r   <= v_n;
        res_r <= res_n;
        bit_r <= bit_r >> 2;
        len_r <= 32'(res_n);
      end
      NM_DIVLD: begin
        rem_r  <= 33'(num[46:16]);
        lo_r   <= num[15:0];
        q_r    <= '0;
        step_r <= '0;
      end
      NM_DIV: begin
        rem_r  <= d_ge ? dsub : t;
        lo_r   <= {lo_r[14:0], 1'b0};
        q_r    <= q_n;
        step_r <= step_r + 4'd1;
        if (step_r == 4'd15) begin
          n_r[comp_r] <= n_fin;
          comp_r      <= comp_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/qsvn_back.sv -----
module qsvn_back (
  input  logic           clk,
  input  logic           rst_n,
  input  qsvn_pkg::op_t  head,
  input  logic           fifo_empty,
  output logic           fifo_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output qsvn_pkg::sum_t out_sum_x,
  output qsvn_pkg::sum_t out_sum_y,
  output qsvn_pkg::sum_t out_sum_z
);
  import qsvn_pkg::*;

  back_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [3*POS_W-1:0] pos_rd_r, pos_wd;
  logic [3*SUM_W-1:0] sum_rd_r, sum_wd;
  addr_t              pos_wa, pos_ra, sum_wa, sum_ra;
  logic               pos_we, sum_we;

  idx_t   idx_r [4];
  pos_t   vx_r [4];
  pos_t   vy_r [4];
  pos_t   vz_r [4];
  logic   fetch_ok_r, read_ok_r;
  mcomp_t m_x_r, m_y_r, m_z_r;
  nrm_t   n_x_r, n_y_r, n_z_r;
  sum_t   out_x_r, out_y_r, out_z_r;

  norm_req_t norm_req;
  norm_res_t norm_res;

  logic [1:0] p, q, vidx;
  logic signed [POS_W:0] pxe, pye, pze, qxe, qye, qze;
  logic signed [POS_W:0] dx, dy, dz, sx, sy, sz;
  logic signed [2*POS_W+1:0] pr_x, pr_y, pr_z;

  function automatic sum_t sat_add(sum_t s, nrm_t n);
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(n);
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return sum_t'(r);
  endfunction

  qsvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (norm_req),
    .res   (norm_res)
  );

  // Newell edge term for the edge from vertex p to vertex p+1.
  always_comb begin
    p    = cnt_r[1:0];
    q    = p + 2'd1;
    vidx = 2'(cnt_r - 3'd1);
    pxe  = {vx_r[p][POS_W-1], vx_r[p]};
    pye  = {vy_r[p][POS_W-1], vy_r[p]};
    pze  = {vz_r[p][POS_W-1], vz_r[p]};
    qxe  = {vx_r[q][POS_W-1], vx_r[q]};
    qye  = {vy_r[q][POS_W-1], vy_r[q]};
    qze  = {vz_r[q][POS_W-1], vz_r[q]};
    dx   = pxe - qxe;
    dy   = pye - qye;
    dz   = pze - qze;
    sx   = pxe + qxe;
    sy   = pye + qye;
    sz   = pze + qze;
    pr_x = dy * sz;
    pr_y = dz * sx;
    pr_z = dx * sy;
  end

  // Next state.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    case (state_r)
      BK_IDLE: begin
        cnt_nxt = '0;
        if (!fifo_empty) begin
          if (head.kind == OP_QUAD) state_nxt = BK_FETCH;
          else if (head.kind == OP_READ && !out_valid_r) state_nxt = BK_RD_WAIT;
        end
      end
      BK_FETCH: begin
        cnt_nxt = (cnt_r == 3'd4) ? 3'd0 : cnt_r + 3'd1;
        if (cnt_r == 3'd4) state_nxt = BK_NEWELL;
      end
      BK_NEWELL: begin
        cnt_nxt = (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
        if (cnt_r == 3'd3) state_nxt = BK_NORM;
      end
      BK_NORM: begin
        cnt_nxt = 3'd1;
        if (norm_res.done) begin
          cnt_nxt   = 3'd0;
          state_nxt = BK_ACC_RD;
        end
      end
      BK_ACC_RD: state_nxt = BK_ACC_WR;
      BK_ACC_WR: begin
        cnt_nxt   = (cnt_r == 3'd3) ? 3'd0 : cnt_r + 3'd1;
        state_nxt = (cnt_r == 3'd3) ? BK_IDLE : BK_ACC_RD;
      end
      BK_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Memory controls and queue pop.
  always_comb begin
    fifo_pop       = 1'b0;
    pos_we         = 1'b0;
    pos_wa         = to_addr(head.idx_a);
    pos_wd         = {head.pos_x, head.pos_y, head.pos_z};
    pos_ra         = to_addr(idx_r[cnt_r[1:0]]);
    sum_we         = 1'b0;
    sum_wa         = to_addr(idx_r[cnt_r[1:0]]);
    sum_ra         = to_addr(idx_r[cnt_r[1:0]]);
    sum_wd         = {sat_add(sum_t'(sum_rd_r[3*SUM_W-1:2*SUM_W]), n_x_r),
                      sat_add(sum_t'(sum_rd_r[2*SUM_W-1:SUM_W]), n_y_r),
                      sat_add(sum_t'(sum_rd_r[SUM_W-1:0]), n_z_r)};
    norm_req.start = 1'b0;
    norm_req.m_x   = m_x_r;
    norm_req.m_y   = m_y_r;
    norm_req.m_z   = m_z_r;
    case (state_r)
      BK_IDLE: begin
        if (!fifo_empty) begin
          case (head.kind)
            OP_LOAD: begin
              fifo_pop = 1'b1;
              pos_we   = in_table(head.idx_a);
            end
            OP_CLEAR: begin
              fifo_pop = 1'b1;
              sum_we   = in_table(head.idx_a);
              sum_wa   = to_addr(head.idx_a);
              sum_wd   = '0;
            end
            OP_QUAD: fifo_pop = 1'b1;
            OP_READ: begin
              fifo_pop = !out_valid_r;
              sum_ra   = to_addr(head.idx_a);
            end
            default: fifo_pop = 1'b0;
          endcase
        end
      end
      BK_NORM:   norm_req.start = cnt_r == 3'd0;
      BK_ACC_WR: sum_we = in_table(idx_r[cnt_r[1:0]]);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Position and sum tables with registered reads.
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_r <= sum_mem[sum_ra];
  end

  // Quad datapath and result register.
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE) begin
      read_ok_r <= in_table(head.idx_a);
      idx_r[0]  <= head.idx_a;
      idx_r[1]  <= head.idx_b;
      idx_r[2]  <= head.idx_d;
      idx_r[3]  <= head.idx_c;
      m_x_r     <= '0;
      m_y_r     <= '0;
      m_z_r     <= '0;
    end
    if (state_r == BK_FETCH) begin
      fetch_ok_r <= in_table(idx_r[cnt_r[1:0]]);
      if (cnt_r != 3'd0) begin
        vx_r[vidx] <= fetch_ok_r ? pos_t'(pos_rd_r[3*POS_W-1:2*POS_W]) : '0;
        vy_r[vidx] <= fetch_ok_r ? pos_t'(pos_rd_r[2*POS_W-1:POS_W]) : '0;
        vz_r[vidx] <= fetch_ok_r ? pos_t'(pos_rd_r[POS_W-1:0]) : '0;
      end
    end
    if (state_r == BK_NEWELL) begin
      m_x_r <= m_x_r + M_W'(pr_x);
      m_y_r <= m_y_r + M_W'(pr_y);
      m_z_r <= m_z_r + M_W'(pr_z);
    end
    if (state_r == BK_NORM && norm_res.done) begin
      n_x_r <= norm_res.n_x;
      n_y_r <= norm_res.n_y;
      n_z_r <= norm_res.n_z;
    end
    if (state_r == BK_RD_WAIT) begin
      out_x_r <= read_ok_r ? sum_t'(sum_rd_r[3*SUM_W-1:2*SUM_W]) : '0;
      out_y_r <= read_ok_r ? sum_t'(sum_rd_r[2*SUM_W-1:SUM_W]) : '0;
      out_z_r <= read_ok_r ? sum_t'(sum_rd_r[SUM_W-1:0]) : '0;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_sum_x = out_x_r;
  assign out_sum_y = out_y_r;
  assign out_sum_z = out_z_r;

endmodule

// ----- rtl/quad_strip_vertex_normals_core.sv -----
// Channel   Handshake            Beat contents
// input     in_push / in_full    in_cmd, in_vertex_index, in_strip_start, in_pos_x/y/z
// result    out_pop / out_empty  out_sum_x, out_sum_y, out_sum_z
//
// An input beat is taken when offered while the four-entry operation queue has room.
// The back end handles a load or clear in its idle state, a read through a wait state
// and a quad in turn: fetch and sum the Newell terms, normalize, then update the sums;
// normalizing scales by up to 30 bits, one bit a cycle, and its square root and the
// three 16-step divisions dominate.
// Reset is synchronous and clears the strip state, the queue and the result valid flag.
// A waiting result stalls the back end at the next read; input beats go on until the
// queue is full.
module quad_strip_vertex_normals_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [1:0]      in_cmd,
  input  qsvn_pkg::idx_t  in_vertex_index,
  input  logic            in_strip_start,
  input  qsvn_pkg::pos_t  in_pos_x,
  input  qsvn_pkg::pos_t  in_pos_y,
  input  qsvn_pkg::pos_t  in_pos_z,
  output logic            out_empty,
  input  logic            out_pop,
  output qsvn_pkg::sum_t  out_sum_x,
  output qsvn_pkg::sum_t  out_sum_y,
  output qsvn_pkg::sum_t  out_sum_z
);
  import qsvn_pkg::*;

  logic accept, op_push, fifo_empty, fifo_pop;
  op_t  op, head;

  assign accept = in_push & ~in_full;

  qsvn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (cmd_t'(in_cmd)),
    .vertex_index (in_vertex_index),
    .strip_start  (in_strip_start),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pos_z        (in_pos_z),
    .op_push      (op_push),
    .op           (op)
  );

  qsvn_op_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op),
    .full    (in_full),
    .pop     (fifo_pop),
    .head    (head),
    .empty   (fifo_empty)
  );

  qsvn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_empty (fifo_empty),
    .fifo_pop   (fifo_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_sum_x  (out_sum_x),
    .out_sum_y  (out_sum_y),
    .out_sum_z  (out_sum_z)
  );

endmodule

// ----- rtl/qsvn_checker.sv -----
module qsvn_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_push,
  input logic            in_full,
  input logic            out_empty,
  input logic            out_pop,
  input qsvn_pkg::sum_t  out_sum_x,
  input qsvn_pkg::sum_t  out_sum_y,
  input qsvn_pkg::sum_t  out_sum_z
);

  // Reset leaves the queue empty and no result waiting.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queue or result not clear after reset");

  // A result beat that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_sum_x) &&
      $stable(out_sum_y) && $stable(out_sum_z)))
    else $error("waiting result changed");

  // The queue can only fill up right after an accepted input beat.
  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("queue became full without an input beat");

  // A read passes through a wait state, so a taken result leaves a gap.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop) |=> out_empty)
    else $error("new result without gap after pop");

endmodule

bind quad_strip_vertex_normals_core qsvn_checker u_qsvn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_sum_x (out_sum_x),
  .out_sum_y (out_sum_y),
  .out_sum_z (out_sum_z)
);

// ----- dv/tb_quad_strip_vertex_normals_core.sv -----
module tb_quad_strip_vertex_normals_core;
  timeunit 1ns;
  timeprecision 1ps;
  import qsvn_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 440;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    cmd_t cmd;
    idx_t idx;
    logic start;
    pos_t x;
    pos_t y;
    pos_t z;
  } vtx_cmd_t;

  typedef struct {
    sum_t x;
    sum_t y;
    sum_t z;
  } vtx_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_cmd = '0;
  idx_t in_vertex_index = '0;
  logic in_strip_start = 1'b0;
  pos_t in_pos_x = '0;
  pos_t in_pos_y = '0;
  pos_t in_pos_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  sum_t out_sum_x;
  sum_t out_sum_y;
  sum_t out_sum_z;

  quad_strip_vertex_normals_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .in_vertex_index(in_vertex_index), .in_strip_start(in_strip_start),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_sum_x(out_sum_x), .out_sum_y(out_sum_y), .out_sum_z(out_sum_z)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vtx_cmd_t pending_cmds[$];
  vtx_sum_t expected_sums[$];
  int errors = 0;
  int cycles = 0;

  // Predictor state: shadow tables and strip pairing.
  pos_t shadow_px[VERTEX_COUNT];
  pos_t shadow_py[VERTEX_COUNT];
  pos_t shadow_pz[VERTEX_COUNT];
  sum_t shadow_sx[VERTEX_COUNT];
  sum_t shadow_sy[VERTEX_COUNT];
  sum_t shadow_sz[VERTEX_COUNT];
  idx_t prev_first = '0;
  idx_t prev_second = '0;
  idx_t held_first = '0;
  bit have_prev = 1'b0;
  bit half_held = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic sum_t add_clamped(sum_t s, longint d);
    longint r;
    r = longint'(s) + d;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return sum_t'(r);
  endfunction

  // Newell normal of quad a, b, d, c, normalized to Q1.15, added to all four sums.
  task automatic add_quad_normal(idx_t a, idx_t b, idx_t c, idx_t d);
    longint px[4];
    longint py[4];
    longint pz[4];
    longint m[3];
    longint n[3];
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned len;
    longint unsigned q;
    bit neg[3];
    idx_t ring[4];
    int i;
    int j;
    ring = '{a, b, d, c};
    for (i = 0; i < 4; i++) begin
      px[i] = shadow_px[ring[i]];
      py[i] = shadow_py[ring[i]];
      pz[i] = shadow_pz[ring[i]];
    end
    m = '{0, 0, 0};
    for (i = 0; i < 4; i++) begin
      j = (i + 1) % 4;
      m[0] += (py[i] - py[j]) * (pz[i] + pz[j]);
      m[1] += (pz[i] - pz[j]) * (px[i] + px[j]);
      m[2] += (px[i] - px[j]) * (py[i] + py[j]);
    end
    mx = 0;
    for (i = 0; i < 3; i++) begin
      neg[i] = m[i] < 0;
      mag[i] = neg[i] ? -m[i] : m[i];
      if (mag[i] > mx) mx = mag[i];
      n[i] = 0;
    end
    if (mx != 0) begin
      while (mx >= (64'd1 << 31)) begin
        for (i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
        for (i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        mx = mx << 1;
      end
      len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (i = 0; i < 3; i++) begin
        q = (mag[i] * 32768 + len / 2) / len;
        if (neg[i]) begin
          if (q > 32768) q = 32768;
          n[i] = -longint'(q);
        end else begin
          if (q > 32767) q = 32767;
          n[i] = q;
        end
      end
    end
    for (i = 0; i < 4; i++) begin
      shadow_sx[ring[i]] = add_clamped(shadow_sx[ring[i]], n[0]);
      shadow_sy[ring[i]] = add_clamped(shadow_sy[ring[i]], n[1]);
      shadow_sz[ring[i]] = add_clamped(shadow_sz[ring[i]], n[2]);
    end
  endtask

  task automatic predict_vertex_cmd(vtx_cmd_t c);
    vtx_sum_t s;
    case (c.cmd)
      CMD_LOAD: begin
        shadow_px[c.idx] = c.x;
        shadow_py[c.idx] = c.y;
        shadow_pz[c.idx] = c.z;
      end
      CMD_CLEAR: begin
        shadow_sx[c.idx] = '0;
        shadow_sy[c.idx] = '0;
        shadow_sz[c.idx] = '0;
      end
      CMD_STRIP: begin
        if (c.start) begin
          have_prev = 1'b0;
          half_held = 1'b0;
        end
        if (!half_held) begin
          held_first = c.idx;
          half_held = 1'b1;
        end else begin
          if (have_prev) add_quad_normal(prev_first, prev_second, held_first, c.idx);
          prev_first = held_first;
          prev_second = c.idx;
          have_prev = 1'b1;
          half_held = 1'b0;
        end
      end
      default: begin
        s.x = shadow_sx[c.idx];
        s.y = shadow_sy[c.idx];
        s.z = shadow_sz[c.idx];
        expected_sums.insert(expected_sums.size(), s);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, sum_t want, sum_t got);
    $display("t=%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // Driver: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    vtx_cmd_t c;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        c.cmd = cmd_t'(in_cmd);
        c.idx = in_vertex_index;
        c.start = in_strip_start;
        c.x = in_pos_x;
        c.y = in_pos_y;
        c.z = in_pos_z;
        predict_vertex_cmd(c);
      end
      if (in_push && in_full) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_cmd <= c.cmd;
        in_vertex_index <= c.idx;
        in_strip_start <= c.start;
        in_pos_x <= c.x;
        in_pos_y <= c.y;
        in_pos_z <= c.z;
        in_push <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor with its own stall pattern, sometimes never stalling.
  logic [7:0] pop_pattern = 8'hff;
  always @(posedge clk) begin
    vtx_sum_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quad_strip_vertex_normals_core: errors");
      $finish;
    end else begin
      if (rst_n && out_pop && !out_empty) begin
        if (expected_sums.size() == 0) begin
          $display("t=%0t unexpected result beat", $realtime);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (out_sum_x !== want.x) report_mismatch("sum_x", want.x, out_sum_x);
          if (out_sum_y !== want.y) report_mismatch("sum_y", want.y, out_sum_y);
          if (out_sum_z !== want.z) report_mismatch("sum_z", want.z, out_sum_z);
        end
      end
      if (cycles % 64 == 0) pop_pattern = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      out_pop <= rst_n && pop_pattern[cycles % 8];
    end
  end

  // Stimulus bookkeeping: only vertices both loaded and cleared enter strips,
  // and only cleared vertices are read.
  bit gen_loaded[VERTEX_COUNT];
  bit gen_cleared[VERTEX_COUNT];
  bit gen_pooled[VERTEX_COUNT];
  idx_t ready_verts[$];
  idx_t cleared_verts[$];

  task automatic queue_cmd(cmd_t cmd, idx_t idx, logic start, pos_t x, pos_t y, pos_t z);
    vtx_cmd_t c;
    c = '{cmd, idx, start, x, y, z};
    pending_cmds.insert(pending_cmds.size(), c);
    if (cmd == CMD_LOAD) gen_loaded[idx] = 1'b1;
    if (cmd == CMD_CLEAR && !gen_cleared[idx]) begin
      gen_cleared[idx] = 1'b1;
      cleared_verts.insert(cleared_verts.size(), idx);
    end
    if (gen_loaded[idx] && gen_cleared[idx] && !gen_pooled[idx]) begin
      gen_pooled[idx] = 1'b1;
      ready_verts.insert(ready_verts.size(), idx);
    end
  endtask

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 3))
      0: return pos_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      1: return pos_t'($urandom_range(0, 1023)) - 16'sd512;
      default: return pos_t'($urandom);
    endcase
  endfunction

  initial begin
    int k;
    int pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme positions, extreme indices, a zero normal from
    // repeated vertices, an odd strip and a restart.
    queue_cmd(CMD_LOAD, 10'd0, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_cmd(CMD_LOAD, 10'd1023, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    queue_cmd(CMD_LOAD, 10'd1, 1'b0, 16'sh0100, 16'sh0000, 16'sh0000);
    queue_cmd(CMD_LOAD, 10'd2, 1'b0, 16'sh0000, 16'sh0100, 16'sh0000);
    queue_cmd(CMD_LOAD, 10'd3, 1'b0, 16'sh0100, 16'sh0100, 16'sh0000);
    for (k = 0; k < 4; k++) queue_cmd(CMD_CLEAR, idx_t'(k), 1'b1, '1, '1, '1);
    queue_cmd(CMD_CLEAR, 10'd1023, 1'b0, '0, '0, '0);
    queue_cmd(CMD_READ, 10'd1023, 1'b1, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd0, 1'b1, '1, '0, '1);
    queue_cmd(CMD_STRIP, 10'd1, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd2, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd3, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1023, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd0, 1'b1, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1023, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1, 1'b1, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1, 1'b0, '0, '0, '0);
    queue_cmd(CMD_STRIP, 10'd1, 1'b0, '0, '0, '0);
    for (k = 0; k < 4; k++) queue_cmd(CMD_READ, idx_t'(k), 1'b0, '0, '0, '0);

    // Random: mostly strips over prepared vertices, with loads, clears and reads.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 || ready_verts.size() < 4) begin
        queue_cmd(CMD_LOAD, idx_t'($urandom), 1'($urandom), rand_pos(), rand_pos(), rand_pos());
        if (ready_verts.size() < 4 || $urandom_range(0, 1))
          queue_cmd(CMD_CLEAR, pending_cmds[$].idx, 1'($urandom), rand_pos(), rand_pos(),
                    rand_pos());
      end else if (pick < 22) begin
        queue_cmd(CMD_CLEAR, idx_t'($urandom), 1'($urandom), rand_pos(), rand_pos(),
                  rand_pos());
      end else if (pick < 78) begin
        queue_cmd(CMD_STRIP, ready_verts[$urandom_range(0, ready_verts.size() - 1)],
                  ($urandom_range(0, 15) == 0), rand_pos(), rand_pos(), rand_pos());
      end else begin
        queue_cmd(CMD_READ, cleared_verts[$urandom_range(0, cleared_verts.size() - 1)],
                  1'($urandom), rand_pos(), rand_pos(), rand_pos());
      end
    end

    // Drain, then let a trailing quad finish.
    wait (pending_cmds.size() == 0 && !in_push && expected_sums.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("tb_quad_strip_vertex_normals_core: clean");
    end else begin
      $display("tb_quad_strip_vertex_normals_core: errors");
    end
    $finish;
  end

endmodule
